[sv/gos_pkg.sv]
// ----------------------------------------------------------------------------
// gos_pkg
// Shared types and constants for the occupancy statistics block.
// ----------------------------------------------------------------------------
package gos_pkg;

	// Width of one light count and of the stored entries
	localparam int unsigned KEY_W      = 16;
	// Fraction bits of the mean
	localparam int unsigned FRAC_W     = 8;
	// Percentile as a ratio
	localparam int unsigned PCT_NUM    = 95;
	localparam int unsigned PCT_DEN    = 100;
	// Rank divide by 100: drop two bits, then multiply by ceil(2^30 / 25) and
	// shift right by 30; exact while the shifted value stays below 2^30
	localparam logic [25:0] RANK_RCP   = 26'd42949673;
	localparam int unsigned RANK_SHR   = 30;
	// Reset value of the per-cluster limit
	localparam logic [15:0] LIMIT_RST  = 16'd256;

	// Output field widths
	localparam int unsigned OCC_OUT_W  = 13;
	localparam int unsigned DROP_OUT_W = 28;
	localparam int unsigned MEAN_OUT_W = 24;

	// Top-level sequencer
	typedef enum logic [1:0] {
		ST_LOAD,
		ST_RANK,
		ST_MEAN,
		ST_FINISH
	} top_state_t;

	// Rank select sequencer
	typedef enum logic [1:0] {
		SEL_IDLE,
		SEL_SCAN,
		SEL_DRAIN
	} sel_state_t;

endpackage

[sv/gos_store.sv]
// ----------------------------------------------------------------------------
// gos_store
// Single-port-write, single-port-read count store with registered read data.
// ----------------------------------------------------------------------------
module gos_store
	import gos_pkg::*;
#(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [KEY_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [KEY_W-1:0] rdata
);

	logic [KEY_W-1:0] mem [DEPTH];
	logic [KEY_W-1:0] rdata_q;

	// Write the new entry and register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/gos_div.sv]
// ----------------------------------------------------------------------------
// gos_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gos_div
	import gos_pkg::*;
#(
	parameter int unsigned DIV_W = 37,
	parameter int unsigned DVS_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int unsigned CW = $clog2(DIV_W + 1);

	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DVS_W:0]   rem_sh;
	logic [DVS_W:0]   rem_sub;
	logic             fits;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_W-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		fits    = rem_sh >= {1'b0, dvs_q};
	end

	// Control: count the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(DIV_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = busy_q && (cnt_q == CW'(DIV_W - 1));
	assign quotient = quo_q;

endmodule

[sv/gos_select.sv]
// ----------------------------------------------------------------------------
// gos_select
// Rank select over the stored counts: a bitwise search on the value, one
// scan of the store per value bit, counting entries below the candidate.
// ----------------------------------------------------------------------------
module gos_select
	import gos_pkg::*;
#(
	parameter int unsigned CNT_W = 13,
	parameter int unsigned AW    = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CNT_W-1:0] n,
	input  logic [CNT_W-1:0] k,
	output logic             rd_en,
	output logic [AW-1:0]    rd_addr,
	input  logic [KEY_W-1:0] rd_data,
	output logic             done,
	output logic [KEY_W-1:0] result
);

	localparam int unsigned BW = $clog2(KEY_W);

	sel_state_t       state_q;
	sel_state_t       state_nxt;
	logic [AW-1:0]    addr_q;
	logic [BW-1:0]    bit_q;
	logic [CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0] res_q;
	logic             vld_s1;
	logic [KEY_W-1:0] cand;
	logic             hit;
	logic [CNT_W-1:0] cnt_fin;
	logic             addr_last;

	// Candidate value and running count of entries below it
	always_comb begin
		cand      = res_q | (KEY_W'(1) << bit_q);
		hit       = vld_s1 && (rd_data < cand);
		cnt_fin   = cnt_q + CNT_W'(hit);
		addr_last = CNT_W'(addr_q) == (n - CNT_W'(1));
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			SEL_IDLE: begin
				if (start) begin
					state_nxt = SEL_SCAN;
				end
			end
			SEL_SCAN: begin
				if (addr_last) begin
					state_nxt = SEL_DRAIN;
				end
			end
			SEL_DRAIN: begin
				state_nxt = (bit_q == '0) ? SEL_IDLE : SEL_SCAN;
			end
			default: begin
				state_nxt = SEL_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		rd_en = 1'b0;
		done  = 1'b0;
		case (state_q)
			SEL_SCAN: begin
				rd_en = 1'b1;
			end
			SEL_DRAIN: begin
				done = bit_q == '0;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEL_IDLE;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			vld_s1  <= rd_en;
		end
	end

	// Scan counters and the value built up bit by bit
	always_ff @(posedge clk) begin
		case (state_q)
			SEL_IDLE: begin
				if (start) begin
					res_q  <= '0;
					bit_q  <= BW'(KEY_W - 1);
					addr_q <= '0;
					cnt_q  <= '0;
				end
			end
			SEL_SCAN: begin
				addr_q <= addr_q + AW'(1);
				cnt_q  <= cnt_fin;
			end
			SEL_DRAIN: begin
				// Keep the bit if no more than k entries lie below the candidate
				if (cnt_fin <= k) begin
					res_q <= cand;
				end
				bit_q  <= bit_q - BW'(1);
				addr_q <= '0;
				cnt_q  <= '0;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign rd_addr = addr_q;
	assign result  = res_q;

endmodule

[sv/grid_occupancy_stats_p95_top.sv]
// Sequence: after the last count of a set the block goes straight to the finish state
// when nothing is occupied, otherwise through the rank step, and then the mean divide
// and the rank scan run side by side; the result is loaded into the output register
// once the result side is not stalling.
// Throughput: one count per cycle while loading; the rank scan over the count
// store (16 passes, one read per cycle) sets the per-set tail.
// Reset: accumulators cleared, limit 256; the count store is not cleared.
// ----------------------------------------------------------------------------
// grid_occupancy_stats_p95_top
// Occupancy statistics with a 95th-percentile select over the nonzero counts.
// ----------------------------------------------------------------------------
module grid_occupancy_stats_p95_top
	import gos_pkg::*;
#(
	parameter int unsigned CLUSTERS = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	// Configuration: per_cluster_limit
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	// Input stream
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [15:0]   s_tdata,   // [15:0] cluster lights
	input  logic          s_tlast,   // is_last
	// Result stream
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [111:0]  m_tdata    // [12:0] occupied_clusters, [28:13] peak lights,
	                                 // [41:29] overflowed_clusters, [69:42] dropped_lights,
	                                 // [93:70] mean_count, [109:94] p95_count, [111:110] zero
);

	localparam int unsigned CNT_W = $clog2(CLUSTERS + 1);
	localparam int unsigned AW    = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
	localparam int unsigned SUM_W = KEY_W + CNT_W;
	localparam int unsigned DIV_W = SUM_W + FRAC_W;
	localparam int unsigned DVS_W = CNT_W;

	top_state_t       state_q;
	top_state_t       state_nxt;
	logic [15:0]      limit_q;
	logic [CNT_W-1:0] items_q;
	logic [CNT_W-1:0] occ_q;
	logic [SUM_W-1:0] sum_q;
	logic [KEY_W-1:0] max_q;
	logic [CNT_W-1:0] ovf_q;
	logic [SUM_W-1:0] drop_q;
	logic [CNT_W+4:0] rank_s1;
	logic [CNT_W-1:0] rank_q;
	logic             go_q;
	logic             div_ok_q;
	logic             sel_ok_q;
	logic             out_vld_q;
	logic [111:0]     out_q;

	logic             accept;
	logic             take;
	logic             store_we;
	logic             out_load;
	logic             div_start;
	logic             sel_start;
	logic [DIV_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic             div_done;
	logic [DIV_W-1:0] div_quo;
	logic             sel_done;
	logic [KEY_W-1:0] sel_result;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [KEY_W-1:0] rd_data;
	logic [CNT_W+6:0] occ95;
	logic [CNT_W+30:0] rank_prod;
	logic [CNT_W+12:0] occ_ext;
	logic [CNT_W+12:0] ovf_ext;
	logic [SUM_W+27:0] drop_ext;
	logic [MEAN_OUT_W-1:0] mean_out;
	logic [KEY_W-1:0] p95_out;

	// Input handshake and which counts enter the set
	always_comb begin
		accept   = s_tvalid && s_tready;
		take     = items_q < CNT_W'(CLUSTERS);
		store_we = accept && take && (s_tdata != '0);
		out_load = (state_q == ST_FINISH) && (!out_vld_q || m_tready);
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && s_tlast) begin
					state_nxt = (store_we || occ_q != '0) ? ST_RANK : ST_FINISH;
				end
			end
			ST_RANK: begin
				if (!go_q) begin
					state_nxt = ST_MEAN;
				end
			end
			ST_MEAN: begin
				if ((div_ok_q || div_done) && (sel_ok_q || sel_done)) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_nxt = ST_LOAD;
				end
			end
			default: begin
				state_nxt = ST_LOAD;
			end
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		occ95        = (CNT_W + 7)'(occ_q) * (CNT_W + 7)'(PCT_NUM);
		rank_prod    = (CNT_W + 31)'(rank_s1) * (CNT_W + 31)'(RANK_RCP);
		s_tready     = 1'b0;
		div_start    = 1'b0;
		sel_start    = 1'b0;
		div_dividend = {sum_q, {FRAC_W{1'b0}}};
		div_divisor  = DVS_W'(occ_q);
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
			end
			ST_MEAN: begin
				div_start = go_q;
				sel_start = go_q;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			limit_q   <= LIMIT_RST;
			items_q   <= '0;
			occ_q     <= '0;
			sum_q     <= '0;
			max_q     <= '0;
			ovf_q     <= '0;
			drop_q    <= '0;
			go_q      <= 1'b0;
			div_ok_q  <= 1'b0;
			sel_ok_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			go_q    <= (state_nxt != state_q) &&
			           (state_nxt == ST_RANK || state_nxt == ST_MEAN);

			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end

			// Accumulate the statistics of one count
			if (accept && take) begin
				items_q <= items_q + CNT_W'(1);
			end
			if (store_we) begin
				occ_q <= occ_q + CNT_W'(1);
				sum_q <= sum_q + SUM_W'(s_tdata);
				if (s_tdata > max_q) begin
					max_q <= s_tdata;
				end
				if (s_tdata > limit_q) begin
					ovf_q  <= ovf_q + CNT_W'(1);
					drop_q <= drop_q + SUM_W'(s_tdata - limit_q);
				end
			end

			// Track completion of the mean divide and the rank scan
			if (go_q) begin
				div_ok_q <= 1'b0;
				sel_ok_q <= 1'b0;
			end else if (state_q == ST_MEAN) begin
				div_ok_q <= div_ok_q || div_done;
				sel_ok_q <= sel_ok_q || sel_done;
			end

			// Hand the result to the output register and start a new set
			if (out_load) begin
				out_vld_q <= 1'b1;
				items_q   <= '0;
				occ_q     <= '0;
				sum_q     <= '0;
				max_q     <= '0;
				ovf_q     <= '0;
				drop_q    <= '0;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Rank of the pick: scale by 95 and drop two bits, then divide by 25 by reciprocal
	always_ff @(posedge clk) begin
		if (state_q == ST_RANK) begin
			if (go_q) begin
				rank_s1 <= occ95[CNT_W+6:2];
			end else begin
				rank_q <= rank_prod[RANK_SHR +: CNT_W];
			end
		end
	end

	// Result fields, masked to their widths
	always_comb begin
		occ_ext  = (CNT_W + 13)'(occ_q);
		ovf_ext  = (CNT_W + 13)'(ovf_q);
		drop_ext = (SUM_W + 28)'(drop_q);
		mean_out = (occ_q == '0) ? '0 : div_quo[MEAN_OUT_W-1:0];
		p95_out  = (occ_q == '0) ? '0 : sel_result;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= {2'b00, p95_out, mean_out, drop_ext[DROP_OUT_W-1:0],
			          ovf_ext[OCC_OUT_W-1:0], max_q, occ_ext[OCC_OUT_W-1:0]};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	gos_store #(
		.DEPTH (CLUSTERS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (occ_q[AW-1:0]),
		.wdata (s_tdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	gos_div #(
		.DIV_W (DIV_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	gos_select #(
		.CNT_W (CNT_W),
		.AW    (AW)
	) u_select (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sel_start),
		.n       (occ_q),
		.k       (rank_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.done    (sel_done),
		.result  (sel_result)
	);

endmodule

[tb/sv/gos_checker.sv]
// ----------------------------------------------------------------------------
// gos_checker
// Watches the count and result streams of the occupancy statistics block,
// predicts the statistics of every set and compares each result transfer
// field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module gos_checker
	import gos_pkg::*;
#(
	parameter int unsigned CLUSTERS = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	input  logic          s_tvalid,
	input  logic          s_tready,
	input  logic [15:0]   s_tdata,
	input  logic          s_tlast,
	input  logic          m_tvalid,
	input  logic          m_tready,
	input  logic [111:0]  m_tdata,
	output int unsigned   fail_count,
	output int unsigned   sets_pending,
	output int unsigned   sets_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	// Statistics of one finished set, one member per result field
	typedef struct {
		logic [12:0] occupied;
		logic [15:0] peak;
		logic [12:0] overflowed;
		logic [27:0] dropped;
		logic [23:0] mean;
		logic [15:0] p95;
	} set_stats_t;

	// Mirror of the block: limit register and the set being loaded
	logic [15:0]     limit_now;
	logic [15:0]     set_counts[$];
	int unsigned     counts_seen;
	longint unsigned count_total;
	longint unsigned drop_total;
	logic [15:0]     count_peak;
	int unsigned     over_tally;
	set_stats_t      stats_q[$];

	function automatic void clear_set();
		set_counts.delete();
		counts_seen = 0;
		count_total = 0;
		drop_total  = 0;
		count_peak  = '0;
		over_tally  = 0;
	endfunction

	// Close a set: tallies, truncated Q16.8 mean and the ascending rank pick
	function automatic set_stats_t close_set();
		set_stats_t      st;
		logic [15:0]     ordered[$];
		int unsigned     occ;
		int unsigned     rank;
		longint unsigned mean_full;
		occ = set_counts.size();
		st.occupied   = occ[12:0];
		st.peak       = count_peak;
		st.overflowed = over_tally[12:0];
		st.dropped    = drop_total[27:0];
		st.mean       = '0;
		st.p95        = '0;
		if (occ != 0) begin
			rank = (occ * PCT_NUM) / PCT_DEN;
			mean_full = (count_total << FRAC_W) / occ;
			ordered = set_counts;
			ordered.sort();
			st.mean = mean_full[23:0];
			st.p95  = ordered[rank];
		end
		return st;
	endfunction

	// Fold one accepted count into the set; past capacity it is dropped
	function automatic void take_count(input logic [15:0] cnt, input logic last);
		if (counts_seen < CLUSTERS) begin
			counts_seen++;
			if (cnt != 0 && set_counts.size() < CLUSTERS) begin
				set_counts.insert(set_counts.size(), cnt);
				count_total += cnt;
				if (cnt > count_peak)
					count_peak = cnt;
				if (cnt > limit_now) begin
					over_tally++;
					drop_total += cnt - limit_now;
				end
			end
		end
		if (last) begin
			stats_q.insert(stats_q.size(), close_set());
			clear_set();
		end
	endfunction

	function automatic void note_error(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endfunction

	function automatic void check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got)
			note_error($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
	endfunction

	// Compare one result transfer with the oldest pending set
	function automatic void check_result(input logic [111:0] d);
		set_stats_t exp_st;
		if (stats_q.size() == 0) begin
			note_error($sformatf("result with no set pending: 0x%0h", d));
			return;
		end
		exp_st = stats_q.pop_front();
		check_field("occupied_clusters", exp_st.occupied, d[12:0]);
		check_field("peak lights", exp_st.peak, d[28:13]);
		check_field("overflowed_clusters", exp_st.overflowed, d[41:29]);
		check_field("dropped_lights", exp_st.dropped, d[69:42]);
		check_field("mean_count", exp_st.mean, d[93:70]);
		check_field("p95_count", exp_st.p95, d[109:94]);
		check_field("tdata padding", 0, d[111:110]);
		sets_checked++;
	endfunction

	// Sample all channels at the rising edge; results are checked first
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_now = LIMIT_RST;
			clear_set();
			stats_q.delete();
			fail_count   = 0;
			sets_checked = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (cfg_we)
				limit_now = cfg_wdata;
			if (s_tvalid && s_tready)
				take_count(s_tdata, s_tlast);
		end
		sets_pending = stats_q.size();
	end

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the occupancy statistics block: directed sets,
// then random sets under several limits with random stalls on both streams.
// Checking is done by gos_checker.
// ----------------------------------------------------------------------------
module tb_top;
	import gos_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CLUSTERS    = 4096;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned SETTLE      = 60;
	localparam int unsigned PHASE_ITEMS = 220;
	localparam int unsigned PHASES      = 6;

	logic          clk;
	logic          arst_n;
	logic          cfg_we;
	logic [15:0]   cfg_wdata;
	logic          s_tvalid;
	logic          s_tready;
	logic [15:0]   s_tdata;   // [15:0] cluster lights
	logic          s_tlast;   // is_last
	logic          m_tvalid;
	logic          m_tready;
	logic [111:0]  m_tdata;   // [12:0] occupied, [28:13] max, [41:29] overflowed,
	                          // [69:42] dropped, [93:70] mean, [109:94] p95, [111:110] zero

	int unsigned   fail_count;
	int unsigned   sets_pending;
	int unsigned   sets_checked;
	int unsigned   cycles;
	int unsigned   counts_sent;
	int unsigned   sets_sent;
	int unsigned   stall_left;
	logic          idle_en;
	logic [15:0]   limit_cur;

	grid_occupancy_stats_p95_top #(
		.CLUSTERS (CLUSTERS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	gos_checker #(
		.CLUSTERS (CLUSTERS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.sets_pending (sets_pending),
		.sets_checked (sets_checked)
	);

	// Clock
	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result backpressure: random stall bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 13);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Drive one count and hold it until the transfer completes
	task automatic send_count(input logic [15:0] cnt, input logic last);
		@(negedge clk);
		if (idle_en && $urandom_range(0, 11) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= cnt;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		counts_sent++;
		if (last)
			sets_sent++;
	endtask

	// Hold off the sender until every set is reported and the block is idle
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sets_pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_limit(input logic [15:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		limit_cur = val;
	endtask

	// Mix of zeros, limit edges, field extremes, small and full-range counts
	function automatic logic [15:0] pick_count();
		int unsigned sel;
		sel = $urandom_range(0, 15);
		case (sel)
			0, 1, 2, 3: return 16'd0;
			4:          return 16'hFFFF;
			5:          return 16'd1;
			6:          return limit_cur;
			7:          return limit_cur + 16'd1;
			8:          return limit_cur - 16'd1;
			9, 10, 11:  return 16'($urandom_range(1, 600));
			default:    return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Random sets, mostly short, now and then a long one
	task automatic random_sets(input int unsigned budget, input logic quiet);
		int unsigned used;
		int unsigned len;
		used = 0;
		while (used < budget) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
			idle_en <= !quiet && ($urandom_range(0, 3) != 0);
			for (int unsigned i = 0; i < len; i++)
				send_count(pick_count(), i == len - 1);
			used += len;
		end
	endtask

	initial begin
		logic [15:0] limits[PHASES];
		logic [15:0] mixed[8];
		clk       = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		idle_en   = 1'b0;
		stall_left  = 0;
		cycles      = 0;
		counts_sent = 0;
		sets_sent   = 0;
		limit_cur   = LIMIT_RST;
		mixed = '{16'd1, 16'd0, 16'd256, 16'd257, 16'd255, 16'h5555, 16'hAAAA, 16'h8000};
		limits = '{16'd0, 16'd1, 16'hFFFF, 16'($urandom_range(2, 65534)),
			16'($urandom_range(2, 600)), LIMIT_RST};

		// Reset once
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty set, single extreme, mixed bits, zero on last, rank pick
		send_count(16'd0, 1'b1);
		send_count(16'hFFFF, 1'b1);
		foreach (mixed[i])
			send_count(mixed[i], i == 7);
		send_count(16'd7, 1'b0);
		send_count(16'd0, 1'b1);
		for (int unsigned i = 0; i < 10; i++)
			send_count(16'(900 - 100 * i), i == 9);

		// Random phases, one limit each; no idling in the last one
		for (int unsigned ph = 0; ph < PHASES; ph++) begin
			write_limit(limits[ph]);
			random_sets(PHASE_ITEMS, ph == PHASES - 1);
		end

		// Let everything drain
		drain();
		$display("covered %0d counts in %0d sets, %0d results compared", counts_sent,
			sets_sent, sets_checked);
		$display("limits 0, 1, 65535, reset value and two random ones, stalls on both sides");
		if (fail_count == 0 && sets_pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
